// File: design/cs_pkg.sv
// shared types, character codes and the scan function of the comment stripper
package cs_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_NESTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned LVL_W      = 3;

  typedef enum logic [1:0] {
    SCAN_PLAIN,
    SCAN_LINECMT,
    SCAN_NESTED
  } scan_code_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_done;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // results of one accepted item, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             full2;
  } fifo_stat_t;

  typedef struct packed {
    logic [7:0] held_char;
    logic       held_valid;
    logic       in_string;
    logic       in_block_comment;
    logic       dropping_line;
    logic       stopped;
  } scan_state_t;

  typedef struct packed {
    scan_code_t code;
    logic [7:0] o;
    logic       blank;
    logic       in_blk;
    logic       in_str;
  } scan_res_t;

  // classify c with optional lookahead n
  function automatic scan_res_t scan_char(logic [7:0] c, logic [7:0] n, logic has_n,
                                          logic in_blk, logic in_str);
    scan_res_t  r;
    logic [7:0] ch;
    r.in_str = in_str ^ ((c == CH_QUOTE) && !in_blk);
    r.in_blk = in_blk;
    r.blank  = 1'b0;
    r.code   = SCAN_PLAIN;
    r.o      = 8'h00;
    ch       = c;
    priority if (has_n && c == CH_SLASH && n == CH_SLASH && !in_blk && !r.in_str) begin
      r.code = SCAN_LINECMT;
      r.o    = CH_NL;
    end else if (has_n && c == CH_SLASH && n == CH_STAR && !r.in_str) begin
      if (in_blk) begin
        r.code = SCAN_NESTED;
      end else begin
        r.in_blk = 1'b1;
        r.blank  = 1'b1;
      end
    end else if (has_n && c == CH_STAR && n == CH_SLASH && in_blk) begin
      ch       = CH_SP;
      r.in_blk = 1'b0;
      r.blank  = 1'b1;
    end else begin
    end
    if (r.code == SCAN_PLAIN) begin
      r.o = (r.in_blk && ch != CH_NL) ? CH_SP : ch;
    end
    return r;
  endfunction

endpackage

// File: design/cs_ifs.sv
// valid/ready channel interfaces for source text and cleaned text
interface cs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_line;
  logic       end_of_source;

  modport source (output valid, in_char, end_of_line, end_of_source, input ready);
  modport sink   (input valid, in_char, end_of_line, end_of_source, output ready);
endinterface

interface cs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       line_done;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, out_char, line_done, error_code, last, input ready);
  modport sink   (input valid, out_char, line_done, error_code, last, output ready);
endinterface

// File: design/cs_scan.sv
// scan state registers and per-character classification logic
module cs_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      in_char,
  input  logic            end_of_line,
  input  logic            end_of_source,
  output cs_pkg::push_t   push
);

  cs_pkg::scan_state_t state_r, state_nxt;
  cs_pkg::scan_res_t   s0, s1;
  cs_pkg::push_t       res;
  logic                line_end;
  logic [7:0]          cur;
  logic                in_blk1, in_str1;

  assign line_end = end_of_line | end_of_source;

  // held character with the new one as lookahead
  assign s0 = cs_pkg::scan_char(state_r.held_char, in_char, 1'b1,
                                state_r.in_block_comment, state_r.in_string);

  always_comb begin
    cur     = in_char;
    in_blk1 = state_r.in_block_comment;
    in_str1 = state_r.in_string;
    if (state_r.held_valid) begin
      in_blk1 = s0.in_blk;
      in_str1 = s0.in_str;
      if (s0.blank) begin
        cur = cs_pkg::CH_SP;
      end
    end
  end

  // line-ending character, no lookahead
  assign s1 = cs_pkg::scan_char(cur, 8'h00, 1'b0, in_blk1, in_str1);

  always_comb begin
    state_nxt = state_r;
    res       = '0;
    priority if (state_r.stopped) begin
    end else if (state_r.dropping_line) begin
      if (line_end) begin
        state_nxt.dropping_line = 1'b0;
        if (end_of_source) begin
          state_nxt = '0;
        end
      end
    end else begin
      state_nxt.held_valid = 1'b0;
      if (state_r.held_valid && s0.code == cs_pkg::SCAN_NESTED) begin
        res.cnt              = 2'd1;
        res.r0.error_code    = cs_pkg::ERR_NESTED;
        res.r0.last          = 1'b1;
        state_nxt.stopped    = 1'b1;
      end else if (state_r.held_valid && s0.code == cs_pkg::SCAN_LINECMT) begin
        res.cnt          = 2'd1;
        res.r0.out_char  = s0.o;
        res.r0.line_done = 1'b1;
        res.r0.last      = 1'b1;
        state_nxt.in_string        = s0.in_str;
        state_nxt.in_block_comment = s0.in_blk;
        if (end_of_source) begin
          state_nxt = '0;
        end else if (!line_end) begin
          state_nxt.dropping_line = 1'b1;
        end
      end else begin
        if (state_r.held_valid) begin
          res.r0.out_char = s0.o;
        end
        if (line_end) begin
          state_nxt.in_string        = s1.in_str;
          state_nxt.in_block_comment = s1.in_blk;
          if (state_r.held_valid) begin
            res.cnt         = 2'd2;
            res.r1.out_char  = s1.o;
            res.r1.line_done = 1'b1;
            res.r1.last      = 1'b1;
          end else begin
            res.cnt          = 2'd1;
            res.r0.out_char  = s1.o;
            res.r0.line_done = 1'b1;
            res.r0.last      = 1'b1;
          end
          if (end_of_source) begin
            if (s1.in_blk) begin
              state_nxt.stopped = 1'b1;
              if (state_r.held_valid) begin
                res.r1.error_code = cs_pkg::ERR_UNTERM;
              end else begin
                res.r0.error_code = cs_pkg::ERR_UNTERM;
              end
            end else begin
              state_nxt = '0;
            end
          end
        end else begin
          state_nxt.in_string        = in_str1;
          state_nxt.in_block_comment = in_blk1;
          state_nxt.held_char        = cur;
          state_nxt.held_valid       = 1'b1;
          if (state_r.held_valid) begin
            res.cnt     = 2'd1;
            res.r0.last = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (acc) begin
      state_r <= state_nxt;
    end
  end

  assign push = acc ? res : '0;

endmodule

// File: design/cs_out_fifo.sv
// four-entry result queue, takes up to two results per cycle
module cs_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  cs_pkg::push_t      push,
  input  logic               pop,
  output cs_pkg::res_t       head,
  output cs_pkg::fifo_stat_t stat
);

  cs_pkg::res_t                mem_r [cs_pkg::FIFO_DEPTH];
  cs_pkg::res_t                head_r;
  logic [cs_pkg::PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cs_pkg::PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cs_pkg::LVL_W-1:0]    level_r, level_nxt;
  logic [cs_pkg::PTR_W-1:0]    wr_ptr1;

  assign wr_ptr1    = wr_ptr_r + cs_pkg::PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + push.cnt[cs_pkg::PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + cs_pkg::PTR_W'(pop);
  assign level_nxt  = level_r + cs_pkg::LVL_W'(push.cnt) - cs_pkg::LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  // next head, taken from the incoming result when it lands on the read slot
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0 && wr_ptr_r == rd_ptr_nxt) begin
      head_r <= push.r0;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign head       = head_r;
  assign stat.level = level_r;
  // set when fewer than two result slots are free
  assign stat.full2 = level_r > cs_pkg::LVL_W'(cs_pkg::FIFO_DEPTH - 2);

endmodule

// File: design/comment_stripper_core.sv
// Comment stripper: takes C source one character per transfer on in_ch and
// gives cleaned text on out_ch. Line comments become a newline with the rest
// of the line dropped; block comment bodies become spaces, newlines kept.
// Each in_ch transfer carries a byte with end_of_line / end_of_source flags;
// each out_ch transfer carries a byte, line_done, error_code and last.
// A character that does not end a line is held for one-character lookahead
// and comes out when the next character arrives; a line-ending character
// comes out with it, so one transfer yields zero, one or two results.
// Results are written into a four-entry queue at the input transfer and are
// registered there; a result written into an empty queue is shown at the
// queue head in the next cycle. in_ch takes one character per cycle while
// the queue has room for two results; the output port carries a single
// result per transfer. When out_ch stalls the queue fills and in_ch.ready
// drops; nothing is lost. After a nested opener or an open
// block comment at end of source an error result is given and all later
// input is taken and discarded until reset. Synchronous reset clears all
// scan state and empties the queue.
module comment_stripper_core (
  input  logic      clk,
  input  logic      rst_n,
  cs_in_if.sink     in_ch,
  cs_out_if.source  out_ch
);

  cs_pkg::push_t      push;
  cs_pkg::res_t       head;
  cs_pkg::fifo_stat_t stat;
  logic               acc;
  logic               pop;

  assign in_ch.ready = !stat.full2;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  cs_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_char       (in_ch.in_char),
    .end_of_line   (in_ch.end_of_line),
    .end_of_source (in_ch.end_of_source),
    .push          (push)
  );

  cs_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  assign out_ch.valid      = stat.level != '0;
  assign out_ch.out_char   = head.out_char;
  assign out_ch.line_done  = head.line_done;
  assign out_ch.error_code = head.error_code;
  assign out_ch.last       = head.last;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= cs_pkg::LVL_W'(cs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> !stat.full2)
    else $error("results pushed without room");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.error_code != cs_pkg::ERR_NONE || out_ch.line_done)
      |-> out_ch.last)
    else $error("error or line end result not marked last");

  a_stop_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 && push.r0.error_code == cs_pkg::ERR_NESTED |=> push.cnt == 2'd0)
    else $error("results after nested comment error");
`endif

endmodule
